[hdl/ihrc_pkg.sv]
// Package: shared types and constants for the IPv4 header receive check.
package ihrc_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65535;
    localparam int QUEUE_DEPTH_DEF      = 2;
    localparam int PKT_CNT_W            = 16;
    localparam int EXT_W                = 6;
    localparam logic [3:0]  IP_VERSION4   = 4'd4;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam logic [EXT_W-1:0] MIN_EXTENT = 6'd20;
    localparam logic [15:0] SUM_GOOD      = 16'hffff;
    localparam logic [31:0] BCAST_ADDR    = 32'hffffffff;
    localparam logic [4:0]  POS_TTL       = 5'd8;
    localparam logic [4:0]  POS_DST_FIRST = 5'd16;
    localparam logic [4:0]  POS_DST_END   = 5'd20;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_VERSION  = 3'd2,
        ST_HDR_LEN  = 3'd3,
        ST_TTL      = 3'd4,
        ST_DEST     = 3'd5,
        ST_TRUNC    = 3'd6
    } t_status;

    typedef struct packed {
        logic [PKT_CNT_W-1:0] count;
        logic [15:0]          sum;
        logic [3:0]           ver;
        logic [3:0]           ihl;
        logic [7:0]           ttl;
        logic [31:0]          dst;
    } t_pkt_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [EXT_W-1:0] hdr_extent(input logic [3:0] ihl);
        hdr_extent = (ihl >= MIN_IHL) ? {ihl, 2'b00} : MIN_EXTENT;
    endfunction

endpackage

[hdl/ihrc_if.sv]
// Interfaces: byte input, verdict output and configuration write channels.
interface ihrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihrc_verdict_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] payload_length;
    modport source (output valid, output status, output payload_length, input ready);
    modport sink   (input valid, input status, input payload_length, output ready);
endinterface

interface ihrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] local_address;
    modport source (output valid, output local_address, input ready);
    modport sink   (input valid, input local_address, output ready);
endinterface

[hdl/ihrc_front.sv]
// Front end: per-byte field capture, header sum and packet record build.
module ihrc_front
    import ihrc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ihrc_byte_if.sink    i_byte,
    input  t_q_stat      i_q_stat,
    output logic         o_push,
    output t_pkt_rec     o_rec
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_sum, n_sum;
    logic [7:0]       r_hold, n_hold;
    logic [3:0]       r_ver, n_ver;
    logic [3:0]       r_ihl, n_ihl;
    logic [7:0]       r_ttl, n_ttl;
    logic [31:0]      r_dst, n_dst;
    logic [16:0]      w_add;
    logic             w_accept;

    assign i_byte.ready = !i_q_stat.full;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_add        = {1'b0, r_sum} + {1'b0, r_hold, i_byte.data_byte};

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_hold  = r_hold;
        n_ver   = r_ver;
        n_ihl   = r_ihl;
        n_ttl   = r_ttl;
        n_dst   = r_dst;
        if (r_count < CNT_MAX) begin
            if (r_count == '0) begin
                n_ver = i_byte.data_byte[7:4];
                n_ihl = i_byte.data_byte[3:0];
            end
            if (r_count == CNT_W'(POS_TTL)) begin
                n_ttl = i_byte.data_byte;
            end
            if (r_count >= CNT_W'(POS_DST_FIRST) && r_count < CNT_W'(POS_DST_END)) begin
                n_dst = {r_dst[23:0], i_byte.data_byte};
            end
            if (r_count < CNT_W'(hdr_extent(n_ihl))) begin
                if (!r_count[0]) begin
                    n_hold = i_byte.data_byte;
                end else begin
                    n_sum = w_add[15:0] + 16'(w_add[16]);
                end
            end
            n_count = r_count + 1'b1;
        end
    end

    assign o_push = w_accept && i_byte.last_byte;

    always_comb begin
        o_rec.count = PKT_CNT_W'(n_count);
        o_rec.sum   = n_sum;
        o_rec.ver   = n_ver;
        o_rec.ihl   = n_ihl;
        o_rec.ttl   = n_ttl;
        o_rec.dst   = n_dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count <= '0;
            r_sum   <= '0;
            r_hold  <= '0;
            r_ver   <= '0;
            r_ihl   <= '0;
            r_ttl   <= '0;
            r_dst   <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_hold  <= n_hold;
            r_ver   <= n_ver;
            r_ihl   <= n_ihl;
            r_ttl   <= n_ttl;
            r_dst   <= n_dst;
        end
    end

endmodule

[hdl/ihrc_queue.sv]
// Queue: short FIFO of packet records between front and back ends.
module ihrc_queue
    import ihrc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_pkt_rec i_rec,
    input  logic     i_pop,
    output t_pkt_rec o_head,
    output t_q_stat  o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_pkt_rec         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/ihrc_back.sv]
// Back end: header checks, verdict output register and local address.
module ihrc_back
    import ihrc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ihrc_cfg_if.sink      i_cfg,
    input  t_pkt_rec      i_head,
    input  t_q_stat       i_q_stat,
    output logic          o_pop,
    ihrc_verdict_if.source o_verdict
);

    logic [31:0]          r_local_address;
    logic                 r_valid;
    t_status              r_status, n_status;
    logic [15:0]          r_payload, n_payload;
    logic [PKT_CNT_W-1:0] w_ext;
    logic [PKT_CNT_W-1:0] w_hdr_bytes;

    assign i_cfg.ready = 1'b1;
    assign o_pop       = !i_q_stat.empty && (!r_valid || o_verdict.ready);
    assign w_ext       = PKT_CNT_W'(hdr_extent(i_head.ihl));
    assign w_hdr_bytes = PKT_CNT_W'({i_head.ihl, 2'b00});

    always_comb begin
        n_payload = '0;
        if (i_head.count < w_ext) begin
            n_status = ST_TRUNC;
        end else if (i_head.sum != SUM_GOOD) begin
            n_status = ST_CHECKSUM;
        end else if (i_head.ver != IP_VERSION4) begin
            n_status = ST_VERSION;
        end else if (i_head.ihl < MIN_IHL) begin
            n_status = ST_HDR_LEN;
        end else if (i_head.ttl == '0) begin
            n_status = ST_TTL;
        end else if (i_head.dst != r_local_address && i_head.dst != BCAST_ADDR) begin
            n_status = ST_DEST;
        end else begin
            n_status  = ST_OK;
            n_payload = 16'(i_head.count - w_hdr_bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
        end else if (i_cfg.valid) begin
            r_local_address <= i_cfg.local_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status  <= n_status;
            r_payload <= n_payload;
        end
    end

    assign o_verdict.valid          = r_valid;
    assign o_verdict.status         = r_status;
    assign o_verdict.payload_length = r_payload;

endmodule

[hdl/ipv4_header_receive_check_core.sv]
// Top level: IPv4 header receive check, front end, record queue and back end.
//
// i_byte carries one packet byte per word, network order, last_byte set on
// the final byte. A new byte is taken every cycle while the record queue has
// room; a packet of any length streams at one byte per cycle.
// o_verdict carries one word per packet: status (0 ok, 1 checksum, 2 version,
// 3 header length, 4 ttl, 5 destination, 6 truncated) and payload_length.
// From the last byte to the verdict, the front end writes the packet record
// into the queue, then the back end runs the checks into its output
// register.
// i_cfg writes the local address; write it only while no packet is in flight.
// Reset clears the per-packet state, the queue, the output valid flag and the
// local address (to 0). A stalled o_verdict holds its word; the queue of
// QUEUE_DEPTH records keeps i_byte flowing until it fills, then i_byte.ready
// drops until the receiver takes a verdict.
module ipv4_header_receive_check_core
    import ihrc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ihrc_byte_if.sink      i_byte,
    ihrc_cfg_if.sink       i_cfg,
    ihrc_verdict_if.source o_verdict
);

    logic     w_push;
    logic     w_pop;
    t_pkt_rec w_rec;
    t_pkt_rec w_head;
    t_q_stat  w_q_stat;

    ihrc_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_rec    (w_rec)
    );

    ihrc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    ihrc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_head    (w_head),
        .i_q_stat  (w_q_stat),
        .o_pop     (w_pop),
        .o_verdict (o_verdict)
    );

`ifndef ASSERT_OFF
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> w_q_stat.empty)
        else $error("queue not empty after reset");

    a_last_byte_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready && i_byte.last_byte) |=> !w_q_stat.empty)
        else $error("last byte did not queue a packet record");

    a_verdict_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_verdict.valid) |-> $past(!w_q_stat.empty))
        else $error("verdict appeared without a queued record");
`endif

endmodule

[tb/sv/ipv4_header_receive_check_core_test.sv]
// Testbench: random and directed IPv4 packets against a scoreboard with a verdict predictor.
`timescale 1ns / 100ps

module ipv4_header_receive_check_core_test;
    import ihrc_pkg::*;

    localparam int MAX_BYTES = 65535;

    typedef logic [7:0] t_octet_q[$];

    typedef struct {
        t_status     status;
        logic [15:0] payload_length;
    } t_verdict;

    class header_verdict_board;
        logic [31:0] local_addr;
        logic [15:0] byte_count;
        logic [15:0] hdr_sum;
        logic [7:0]  hi_octet;
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [7:0]  ttl;
        logic [31:0] dst;
        t_verdict    expected_verdicts[$];
        int unsigned verdicts_predicted;
        int unsigned mismatches;

        function new();
            local_addr = '0;
            verdicts_predicted = 0;
            mismatches = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_count = '0;
            hdr_sum    = '0;
            hi_octet   = '0;
            version    = '0;
            ihl        = '0;
            ttl        = '0;
            dst        = '0;
        endfunction

        function int unsigned extent();
            return (ihl >= 4'd5) ? ihl * 4 : 20;
        endfunction

        function void note_byte(logic [7:0] octet, logic last);
            logic [16:0] acc;
            t_verdict    v;
            if (byte_count < MAX_BYTES) begin
                if (byte_count == 0) begin
                    version = octet[7:4];
                    ihl     = octet[3:0];
                end
                if (byte_count == 8)
                    ttl = octet;
                if (byte_count >= 16 && byte_count < 20)
                    dst = {dst[23:0], octet};
                if (byte_count < extent()) begin
                    if (!byte_count[0]) begin
                        hi_octet = octet;
                    end else begin
                        acc = {1'b0, hdr_sum} + {1'b0, hi_octet, octet};
                        acc = {1'b0, acc[15:0]} + acc[16];
                        hdr_sum = acc[15:0] + acc[16];
                    end
                end
                byte_count++;
            end
            if (!last)
                return;
            v.payload_length = '0;
            if (byte_count < extent())
                v.status = ST_TRUNC;
            else if (hdr_sum != 16'hffff)
                v.status = ST_CHECKSUM;
            else if (version != 4'd4)
                v.status = ST_VERSION;
            else if (ihl < 4'd5)
                v.status = ST_HDR_LEN;
            else if (ttl == 8'd0)
                v.status = ST_TTL;
            else if (dst != local_addr && dst != 32'hffff_ffff)
                v.status = ST_DEST;
            else begin
                v.status = ST_OK;
                v.payload_length = byte_count - {10'd0, ihl, 2'b00};
            end
            expected_verdicts.push_back(v);
            verdicts_predicted++;
            clear_packet();
        endfunction

        function void check_verdict(logic [2:0] status, logic [15:0] payload_length);
            t_verdict v;
            if (expected_verdicts.size() == 0) begin
                $error("verdict word with none expected: status %0d, payload_length %0d",
                       status, payload_length);
                mismatches++;
                return;
            end
            v = expected_verdicts.pop_front();
            if (status !== v.status) begin
                $error("status: expected %0d, actual %0d", v.status, status);
                mismatches++;
            end
            if (payload_length !== v.payload_length) begin
                $error("payload_length: expected %0d, actual %0d",
                       v.payload_length, payload_length);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ihrc_byte_if    byte_ch();
    ihrc_cfg_if     cfg_ch();
    ihrc_verdict_if verdict_ch();

    header_verdict_board board = new();
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned octets_sent;

    ipv4_header_receive_check_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (byte_ch),
        .i_cfg     (cfg_ch),
        .o_verdict (verdict_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready)
            board.check_verdict(verdict_ch.status, verdict_ch.payload_length);
        verdict_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic t_octet_q build_packet(input logic [3:0] ver, input logic [3:0] ihl,
                                              input logic [7:0] ttl, input logic [31:0] dst,
                                              input int unsigned payload_len);
        t_octet_q    pkt;
        int unsigned hdr_len;
        logic [16:0] acc;
        logic [15:0] total;
        hdr_len = (ihl >= 4'd5) ? ihl * 4 : 20;
        total   = 16'(hdr_len + payload_len);
        for (int i = 0; i < hdr_len + payload_len; i++)
            pkt.push_back(8'($urandom_range(255)));
        pkt[0]  = {ver, ihl};
        pkt[2]  = total[15:8];
        pkt[3]  = total[7:0];
        pkt[8]  = ttl;
        pkt[10] = 8'h00;
        pkt[11] = 8'h00;
        for (int i = 0; i < 4; i++)
            pkt[16 + i] = dst[31 - 8 * i -: 8];
        acc = '0;
        for (int i = 0; i < hdr_len; i += 2) begin
            acc = {1'b0, acc[15:0]} + {1'b0, pkt[i], pkt[i + 1]};
            acc = {1'b0, acc[15:0]} + acc[16];
        end
        {pkt[10], pkt[11]} = ~acc[15:0];
        return pkt;
    endfunction

    task automatic send_byte(input logic [7:0] octet, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= octet;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        board.note_byte(octet, last);
        octets_sent++;
    endtask

    task automatic send_packet(input t_octet_q pkt, input int unsigned n);
        // send only the first n words; 0 sends the whole packet
        int unsigned len;
        len = (n == 0) ? pkt.size() : n;
        for (int i = 0; i < len; i++)
            send_byte(pkt[i], i == len - 1);
    endtask

    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (board.expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_local_address(input logic [31:0] addr);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.local_address <= addr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        board.local_addr = addr;
    endtask

    task automatic send_random_packet();
        t_octet_q    pkt;
        int unsigned kind;
        int unsigned pick;
        int unsigned hdr_len;
        int unsigned n;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  ttl;
        logic [31:0] dst;
        kind = $urandom_range(99);
        ver  = 4'd4;
        ihl  = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(15, 6));
        ttl  = 8'($urandom_range(255, 1));
        pick = $urandom_range(9);
        dst  = (pick < 5) ? board.local_addr : (pick < 7) ? 32'hffff_ffff : $urandom;
        if (kind >= 60 && kind < 70) begin
            do ver = 4'($urandom_range(15)); while (ver == 4'd4);
        end
        if (kind >= 70 && kind < 75)
            ihl = 4'($urandom_range(4));
        if (kind >= 75 && kind < 80)
            ttl = 8'd0;
        hdr_len = (ihl >= 4'd5) ? ihl * 4 : 20;
        pkt = build_packet(ver, ihl, ttl, dst, $urandom_range(15));
        n = 0;
        if (kind >= 80 && kind < 92) begin
            pick = $urandom_range(hdr_len - 1);
            pkt[pick] = pkt[pick] ^ (8'h01 << $urandom_range(7));
        end
        if (kind >= 92 && kind < 96)
            n = $urandom_range(hdr_len - 1, 1);
        if (kind >= 96) begin
            pkt = {};
            repeat ($urandom_range(30, 1)) pkt.push_back(8'($urandom_range(255)));
        end
        send_packet(pkt, n);
    endtask

    task automatic run_random(input int unsigned min_octets, input int unsigned min_verdicts);
        int unsigned octets0;
        int unsigned verdicts0;
        octets0   = octets_sent;
        verdicts0 = board.verdicts_predicted;
        while (octets_sent - octets0 < min_octets ||
               board.verdicts_predicted - verdicts0 < min_verdicts)
            send_random_packet();
    endtask

    initial begin
        t_octet_q pkt;
        i_rst_n              = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'h00;
        byte_ch.last_byte    = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.local_address = 32'h0;
        verdict_ch.ready     = 1'b0;
        octets_sent          = 0;
        src_idle_pct         = 29;
        sink_idle_pct        = 82;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_local_address(32'hc0a8_0a05);
        send_packet(build_packet(4'd4, 4'd5, 8'd64, board.local_addr, 0), 0);
        send_packet(build_packet(4'd4, 4'd5, 8'd255, 32'hffff_ffff, 7), 0);
        send_packet(build_packet(4'd4, 4'd15, 8'd1, board.local_addr, 3), 0);
        pkt = build_packet(4'd4, 4'd5, 8'd30, board.local_addr, 4);
        pkt[12] = pkt[12] ^ 8'h01;
        send_packet(pkt, 0);
        send_packet(build_packet(4'd6, 4'd5, 8'd30, board.local_addr, 2), 0);
        send_packet(build_packet(4'd4, 4'd4, 8'd30, board.local_addr, 2), 0);
        send_packet(build_packet(4'd4, 4'd0, 8'd30, board.local_addr, 0), 0);
        send_packet(build_packet(4'd4, 4'd5, 8'd0, board.local_addr, 0), 0);
        send_packet(build_packet(4'd4, 4'd5, 8'd9, board.local_addr ^ 32'h1, 1), 0);
        send_packet(build_packet(4'd4, 4'd5, 8'd9, board.local_addr, 0), 19);
        send_packet(build_packet(4'd4, 4'd15, 8'd9, board.local_addr, 5), 40);
        send_packet(build_packet(4'd4, 4'd5, 8'd9, board.local_addr, 0), 1);
        pkt = {};
        repeat (20) pkt.push_back(8'h00);
        send_packet(pkt, 0);
        pkt = {};
        repeat (60) pkt.push_back(8'hff);
        send_packet(pkt, 0);

        settle();
        write_local_address($urandom);
        run_random(120, 3);
        settle();
        run_random(120, 3);

        settle();
        src_idle_pct  = 82;
        sink_idle_pct = 29;
        write_local_address(32'hffff_ffff);
        run_random(150, 4);

        settle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_local_address(32'h0000_0000);
        run_random(150, 4);

        settle();
        if (board.expected_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", board.expected_verdicts.size());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
